// ===== sv/mltpf_pkg.sv =====
// Shared types, codes and constants for the memory-LCD test pattern framer.
// No dependencies; used by every module of the block.
package mltpf_pkg;

	localparam int DWELL_WIDTH_DEF = 16;
	localparam int TICKS_W         = 16;
	localparam int CFG_INDEX_W     = 2;
	localparam int CFG_DATA_W      = 16;

	localparam logic [7:0] MODE_BYTE  = 8'h01;
	localparam logic [7:0] ZERO_BYTE  = 8'h00;
	localparam logic [7:0] BLACK_BYTE = 8'hff;
	localparam logic [7:0] AA_BYTE    = 8'haa;
	localparam logic [7:0] BYTE_55    = 8'h55;
	localparam logic [7:0] LAST_LINE  = 8'hff;

	localparam logic [7:0] FRAME_LINES_RST = 8'd240;
	localparam logic [5:0] LINE_BYTES_RST  = 6'd50;
	localparam logic [15:0] DWELL_TICKS_RST = 16'd120;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_FRAME_LINES = 2'd0,
		REG_LINE_BYTES  = 2'd1,
		REG_DWELL_TICKS = 2'd2,
		REG_UNUSED      = 2'd3
	} reg_index_t;

	typedef enum logic [2:0] {
		CMD_TICK     = 3'd0,
		CMD_SELECT   = 3'd1,
		CMD_CYCLE    = 3'd2,
		CMD_HOLD     = 3'd3,
		CMD_SHUTDOWN = 3'd4,
		CMD_START    = 3'd5,
		CMD_NEXT     = 3'd6,
		CMD_NONE     = 3'd7
	} cmd_t;

	typedef enum logic [1:0] {
		PAT_WHITE   = 2'd0,
		PAT_BLACK   = 2'd1,
		PAT_STRIPES = 2'd2,
		PAT_CHECKER = 2'd3
	} pattern_t;

	typedef enum logic [5:0] {
		PH_IDLE  = 6'b000001,
		PH_MODE  = 6'b000010,
		PH_ADDR  = 6'b000100,
		PH_DATA  = 6'b001000,
		PH_DUMMY = 6'b010000,
		PH_TRAIL = 6'b100000
	} phase_t;

	typedef struct packed {
		logic [7:0]         frame_lines;
		logic [5:0]         line_bytes;
		logic [TICKS_W-1:0] dwell_ticks;
	} cfg_t;

	typedef struct packed {
		logic [7:0] wire_byte;
		logic       byte_valid;
		logic       frame_last;
		logic       frame_busy;
		logic [1:0] shown_pattern;
		logic       refresh_on;
		logic       cycling_on;
		logic       display_enable;
		logic       tick_overrun;
	} result_t;

	// pattern byte for a given line; checkerboard alternates per line
	function automatic logic [7:0] fill_byte(input pattern_t pat, input logic [7:0] line);
		logic [7:0] b;
		case (pat)
			PAT_BLACK:   b = BLACK_BYTE;
			PAT_STRIPES: b = AA_BYTE;
			PAT_CHECKER: b = line[0] ? BYTE_55 : AA_BYTE;
			default:     b = ZERO_BYTE;
		endcase
		return b;
	endfunction

endpackage

// ===== sv/memory_lcd_test_pattern_framer.sv =====
// Top level of the memory-LCD test pattern framer: input register, control core,
// result register and configuration port. Depends on mltpf_pkg, mltpf_cfg, mltpf_core.

// Commands enter on s_axis and each one returns exactly one result on m_axis, in
// order. The block sustains one command per clock while m_axis_tready is high: a
// command is registered on acceptance, processed by the control core once the
// result register is empty or being drained, and lands in the result register.
// The single input register and single result register are the only
// buffering; with the result register full and m_axis_tready low, one more
// request is taken into the input register and then s_axis_tready drops. A next
// byte request returns the next frame byte (mode byte, per line address, pattern
// bytes and dummy byte, then the trailing byte flagged by tlast); tuser high
// marks the byte as meaningful. Configuration writes are always accepted and
// should be made only while no request is in flight. Write index 3 is ignored.
module memory_lcd_test_pattern_framer #(
	parameter int DWELL_WIDTH = mltpf_pkg::DWELL_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [2:0] command, [4:3] pattern_choice, [7:5] zero
	input  logic [7:0]  s_axis_tdata,

	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [7:0] wire_byte, [8] frame_busy, [10:9] shown_pattern, [11] refresh_on,
	// [12] cycling_on, [13] display_enable, [14] tick_overrun, [15] zero
	output logic [15:0] m_axis_tdata,
	// [0] byte_valid
	output logic        m_axis_tuser,
	output logic        m_axis_tlast,

	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [mltpf_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [mltpf_pkg::CFG_DATA_W-1:0]    cfg_data
);

	mltpf_pkg::cfg_t    cfg;
	mltpf_pkg::result_t res, res_s2;

	logic       valid_s1;
	logic [2:0] cmd_s1;
	logic [1:0] choice_s1;
	logic       valid_s2;
	logic       advance;

	// stage 1 moves on whenever the result register is empty or being drained
	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign cfg_ready     = 1'b1;

	mltpf_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			cmd_s1    <= s_axis_tdata[2:0];
			choice_s1 <= s_axis_tdata[4:3];
		end
	end

	mltpf_core #(
		.DWELL_WIDTH (DWELL_WIDTH)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.cmd    (cmd_s1),
		.choice (choice_s1),
		.cfg    (cfg),
		.res    (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tuser  = res_s2.byte_valid;
	assign m_axis_tlast  = res_s2.frame_last;
	assign m_axis_tdata  = {1'b0, res_s2.tick_overrun, res_s2.display_enable,
	                        res_s2.cycling_on, res_s2.refresh_on, res_s2.shown_pattern,
	                        res_s2.frame_busy, res_s2.wire_byte};

endmodule

// ===== sv/mltpf_cfg.sv =====
// Configuration register file: frame geometry and dwell length.
// Depends on mltpf_pkg.
module mltpf_cfg (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   wr_en,
	input  logic [mltpf_pkg::CFG_INDEX_W-1:0]      wr_index,
	input  logic [mltpf_pkg::CFG_DATA_W-1:0]       wr_data,
	output mltpf_pkg::cfg_t                        cfg
);

	mltpf_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_lines <= mltpf_pkg::FRAME_LINES_RST;
			cfg_q.line_bytes  <= mltpf_pkg::LINE_BYTES_RST;
			cfg_q.dwell_ticks <= mltpf_pkg::DWELL_TICKS_RST;
		end else if (wr_en) begin
			case (mltpf_pkg::reg_index_t'(wr_index))
				mltpf_pkg::REG_FRAME_LINES: cfg_q.frame_lines <= wr_data[7:0];
				mltpf_pkg::REG_LINE_BYTES:  cfg_q.line_bytes  <= wr_data[5:0];
				mltpf_pkg::REG_DWELL_TICKS: cfg_q.dwell_ticks <= wr_data[mltpf_pkg::TICKS_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== sv/mltpf_core.sv =====
// Control state and frame byte sequencer; one command processed per enable.
// Depends on mltpf_pkg.
module mltpf_core #(
	parameter int DWELL_WIDTH = mltpf_pkg::DWELL_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic [2:0]            cmd,
	input  logic [1:0]            choice,
	input  mltpf_pkg::cfg_t       cfg,
	output mltpf_pkg::result_t    res
);

	localparam int CMP_W = (DWELL_WIDTH > mltpf_pkg::TICKS_W) ? DWELL_WIDTH : mltpf_pkg::TICKS_W;

	mltpf_pkg::pattern_t   pat_q, pat_d, fpat_q, fpat_d;
	mltpf_pkg::phase_t     phase_q, phase_d;
	logic                  refresh_q, refresh_d, cycle_q, cycle_d;
	logic                  started_q, started_d, enable_q, enable_d;
	logic                  pending_q, pending_d;
	logic [DWELL_WIDTH-1:0] dwell_q, dwell_d, dwell_inc;
	logic [7:0]            line_q, line_d;
	logic [5:0]            byte_q, byte_d, byte_inc;
	logic                  busy;
	logic                  dwell_done;

	assign busy      = (phase_q != mltpf_pkg::PH_IDLE);
	assign dwell_inc = (dwell_q != {DWELL_WIDTH{1'b1}}) ? dwell_q + 1'b1 : dwell_q;
	assign dwell_done = CMP_W'(dwell_inc) >= CMP_W'(cfg.dwell_ticks);
	assign byte_inc  = byte_q + 6'd1;

	always_comb begin
		pat_d     = pat_q;
		fpat_d    = fpat_q;
		phase_d   = phase_q;
		refresh_d = refresh_q;
		cycle_d   = cycle_q;
		started_d = started_q;
		enable_d  = enable_q;
		pending_d = pending_q;
		dwell_d   = dwell_q;
		line_d    = line_q;
		byte_d    = byte_q;
		res       = '0;

		case (mltpf_pkg::cmd_t'(cmd))
			mltpf_pkg::CMD_TICK: begin
				dwell_d = dwell_inc;
				if (started_q && cycle_q && dwell_done) begin
					if (pat_q != mltpf_pkg::PAT_CHECKER) begin
						pat_d     = mltpf_pkg::pattern_t'(pat_q + 2'd1);
						refresh_d = 1'b1;
						cycle_d   = 1'b1;
						dwell_d   = '0;
					end else begin
						refresh_d = 1'b0;
						cycle_d   = 1'b0;
					end
				end else if (started_q && refresh_q) begin
					if (busy) begin
						res.tick_overrun = 1'b1;
					end else begin
						fpat_d  = pat_q;
						phase_d = mltpf_pkg::PH_MODE;
						line_d  = '0;
						byte_d  = '0;
					end
				end
			end
			mltpf_pkg::CMD_SELECT: begin
				pat_d     = mltpf_pkg::pattern_t'(choice);
				refresh_d = 1'b1;
				cycle_d   = 1'b0;
				dwell_d   = '0;
			end
			mltpf_pkg::CMD_CYCLE: begin
				pat_d     = mltpf_pkg::PAT_WHITE;
				refresh_d = 1'b1;
				cycle_d   = 1'b1;
				dwell_d   = '0;
			end
			mltpf_pkg::CMD_HOLD: begin
				refresh_d = 1'b0;
				cycle_d   = 1'b0;
			end
			mltpf_pkg::CMD_SHUTDOWN: begin
				refresh_d = 1'b0;
				cycle_d   = 1'b0;
				if (started_q) begin
					started_d = 1'b0;
					if (busy) begin
						pending_d = 1'b1;
					end else begin
						fpat_d  = mltpf_pkg::PAT_WHITE;
						phase_d = mltpf_pkg::PH_MODE;
						line_d  = '0;
						byte_d  = '0;
					end
				end
			end
			mltpf_pkg::CMD_START: begin
				if (!started_q) begin
					started_d = 1'b1;
					pat_d     = mltpf_pkg::PAT_WHITE;
					refresh_d = 1'b1;
					cycle_d   = 1'b1;
					dwell_d   = '0;
					if (!busy) begin
						fpat_d  = mltpf_pkg::PAT_WHITE;
						phase_d = mltpf_pkg::PH_MODE;
						line_d  = '0;
						byte_d  = '0;
					end
				end
			end
			mltpf_pkg::CMD_NEXT: begin
				if (busy) begin
					res.byte_valid = 1'b1;
					case (phase_q)
						mltpf_pkg::PH_MODE: begin
							res.wire_byte = mltpf_pkg::MODE_BYTE;
							line_d  = 8'd1;
							phase_d = (cfg.frame_lines == '0) ? mltpf_pkg::PH_TRAIL
							                                  : mltpf_pkg::PH_ADDR;
						end
						mltpf_pkg::PH_ADDR: begin
							res.wire_byte = line_q;
							byte_d  = '0;
							phase_d = (cfg.line_bytes == '0) ? mltpf_pkg::PH_DUMMY
							                                 : mltpf_pkg::PH_DATA;
						end
						mltpf_pkg::PH_DATA: begin
							res.wire_byte = mltpf_pkg::fill_byte(fpat_q, line_q);
							byte_d = byte_inc;
							if (byte_inc == '0 || byte_inc >= cfg.line_bytes)
								phase_d = mltpf_pkg::PH_DUMMY;
						end
						mltpf_pkg::PH_DUMMY: begin
							res.wire_byte = mltpf_pkg::ZERO_BYTE;
							if (line_q >= cfg.frame_lines || line_q == mltpf_pkg::LAST_LINE) begin
								phase_d = mltpf_pkg::PH_TRAIL;
							end else begin
								line_d  = line_q + 8'd1;
								phase_d = mltpf_pkg::PH_ADDR;
							end
						end
						default: begin
							// trailing byte closes the frame
							res.wire_byte  = mltpf_pkg::ZERO_BYTE;
							res.frame_last = 1'b1;
							phase_d        = mltpf_pkg::PH_IDLE;
							if (pending_q) begin
								pending_d = 1'b0;
								fpat_d    = mltpf_pkg::PAT_WHITE;
								phase_d   = mltpf_pkg::PH_MODE;
								line_d    = '0;
								byte_d    = '0;
							end else begin
								enable_d = started_q;
							end
						end
					endcase
				end
			end
			default: ;
		endcase

		res.frame_busy     = (phase_d != mltpf_pkg::PH_IDLE);
		res.shown_pattern  = pat_d;
		res.refresh_on     = refresh_d;
		res.cycling_on     = cycle_d;
		res.display_enable = enable_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_q     <= mltpf_pkg::PAT_WHITE;
			fpat_q    <= mltpf_pkg::PAT_WHITE;
			phase_q   <= mltpf_pkg::PH_IDLE;
			refresh_q <= 1'b0;
			cycle_q   <= 1'b0;
			started_q <= 1'b0;
			enable_q  <= 1'b0;
			pending_q <= 1'b0;
			dwell_q   <= '0;
			line_q    <= '0;
			byte_q    <= '0;
		end else if (en) begin
			pat_q     <= pat_d;
			fpat_q    <= fpat_d;
			phase_q   <= phase_d;
			refresh_q <= refresh_d;
			cycle_q   <= cycle_d;
			started_q <= started_d;
			enable_q  <= enable_d;
			pending_q <= pending_d;
			dwell_q   <= dwell_d;
			line_q    <= line_d;
			byte_q    <= byte_d;
		end
	end

`ifndef SYNTH
	// a queued shutdown frame only exists behind a frame in flight
	a_pending_busy: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q |-> (phase_q != mltpf_pkg::PH_IDLE))
		else $error("shutdown pending while framer idle");

	// display enable changes only as a frame's trailing byte goes out
	a_enable_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		(enable_q != $past(enable_q)) |->
		$past(en && cmd == mltpf_pkg::CMD_NEXT && phase_q == mltpf_pkg::PH_TRAIL))
		else $error("display enable changed outside frame end");

	// a byte is produced only from a busy framer, and last only with a byte
	a_byte_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(en && res.byte_valid) |-> (busy && (cmd == mltpf_pkg::CMD_NEXT)))
		else $error("byte produced while idle");

	a_last_has_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(en && res.frame_last) |-> (res.byte_valid && !res.frame_busy || pending_q))
		else $error("frame end without byte");
`endif

endmodule
